FILE: rtl/uhtfp_pkg.sv
// ----------------------------------------------------------------------------
// uhtfp_pkg
// Shared types and constants for the header/tail framed packet parser.
// ----------------------------------------------------------------------------
package uhtfp_pkg;

    // Payload lengths per frame type
    localparam int RECT_LEN  = 8;
    localparam int POINT_LEN = 2;

    // Bytes of each store reported on the result ports
    localparam int RECT_OUT_BYTES  = 8;
    localparam int POINT_OUT_BYTES = 2;

    localparam int RECT_IDX_W  = (RECT_LEN  > 1) ? $clog2(RECT_LEN)  : 1;
    localparam int POINT_IDX_W = (POINT_LEN > 1) ? $clog2(POINT_LEN) : 1;
    localparam int COUNT_W     = 4;

    localparam int CFG_INDEX_W = 2;

    // Frame mode codes (other codes ignore bytes)
    localparam logic [1:0] MODE_RECT  = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;

    // Register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'd44;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd18;
    localparam logic [7:0] TAIL_RST          = 8'd91;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_MODE    = 2'd0,
        CFG_HEADER_FIRST  = 2'd1,
        CFG_HEADER_SECOND = 2'd2,
        CFG_TAIL          = 2'd3
    } uhtfp_cfg_idx_t;

    typedef struct packed {
        logic [1:0] frame_mode;
        logic [7:0] header_first_byte;
        logic [7:0] header_second_byte;
        logic [7:0] tail_byte;
    } uhtfp_cfg_t;

    typedef struct packed {
        logic        frame_ok;
        logic [63:0] rect_payload;
        logic [15:0] point_payload;
    } uhtfp_result_t;

endpackage

FILE: rtl/uart_header_tail_frame_parser.sv
// ----------------------------------------------------------------------------
// uart_header_tail_frame_parser
// A result is registered in the output or, on a stall, the skid register.
// Throughput: one byte per cycle; the two-entry result buffer keeps input
// open while one result is stalled, and ready drops only when both are full.
// Reset: parser hunts for the header, stores clear to zero, registers take
// their default values, result buffer empties.
// ----------------------------------------------------------------------------
module uart_header_tail_frame_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               frame_ok,
    output logic [63:0]                        rect_payload,
    output logic [15:0]                        point_payload,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uhtfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [7:0]                         cfg_data
);
    import uhtfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_COLLECT = 2'd2
    } phase_t;

    uhtfp_cfg_t    cfg;
    uhtfp_result_t res_next;
    uhtfp_result_t res_out;
    logic          buf_space;
    logic          accept;

    phase_t               phase_reg,  phase_next;
    logic [COUNT_W-1:0]   count_reg,  count_next;
    logic [7:0]           rect_store_reg  [RECT_LEN];
    logic [7:0]           rect_store_next [RECT_LEN];
    logic [7:0]           point_store_reg  [POINT_LEN];
    logic [7:0]           point_store_next [POINT_LEN];

    logic                 mode_rect;
    logic                 mode_point;
    logic [COUNT_W-1:0]   len;
    logic                 store_wr;
    logic                 ok;

    // Configuration registers
    uhtfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_ready = buf_space;
    assign accept   = in_valid && in_ready;

    assign mode_rect  = (cfg.frame_mode == MODE_RECT);
    assign mode_point = (cfg.frame_mode == MODE_POINT);
    assign len        = mode_rect ? COUNT_W'(RECT_LEN) : COUNT_W'(POINT_LEN);

    // Parser next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        store_wr   = 1'b0;
        ok         = 1'b0;
        if (mode_rect || mode_point)
        begin
            priority if (rx_byte == cfg.header_first_byte && phase_reg == PH_HUNT)
            begin
                phase_next = PH_SECOND;
            end
            else if (rx_byte == cfg.header_second_byte && phase_reg == PH_SECOND)
            begin
                phase_next = PH_COLLECT;
                count_next = '0;
            end
            else if (phase_reg == PH_COLLECT)
            begin
                if (rx_byte != cfg.tail_byte)
                begin
                    if (count_reg < len)
                    begin
                        store_wr   = 1'b1;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        // overlong payload: abort
                        phase_next = PH_HUNT;
                    end
                end
                else
                begin
                    phase_next = PH_HUNT;
                    ok         = (count_reg == len);
                end
            end
            else
            begin
                phase_next = PH_HUNT;
            end
        end
    end

    // Store updates
    always_comb
    begin
        rect_store_next  = rect_store_reg;
        point_store_next = point_store_reg;
        if (store_wr && mode_rect)
        begin
            rect_store_next[count_reg[RECT_IDX_W-1:0]] = rx_byte;
        end
        if (store_wr && mode_point)
        begin
            point_store_next[count_reg[POINT_IDX_W-1:0]] = rx_byte;
        end
    end

    // Result as it stands after this byte
    always_comb
    begin
        res_next               = '0;
        res_next.frame_ok      = ok;
        for (int k = 0; k < RECT_LEN && k < RECT_OUT_BYTES; k++)
        begin
            res_next.rect_payload[8*k +: 8] = rect_store_next[k];
        end
        for (int k = 0; k < POINT_LEN && k < POINT_OUT_BYTES; k++)
        begin
            res_next.point_payload[8*k +: 8] = point_store_next[k];
        end
    end

    // Parser state and stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            for (int k = 0; k < RECT_LEN; k++)
            begin
                rect_store_reg[k] <= '0;
            end
            for (int k = 0; k < POINT_LEN; k++)
            begin
                point_store_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            rect_store_reg  <= rect_store_next;
            point_store_reg <= point_store_next;
        end
    end

    // Result buffer
    uhtfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_next),
        .space     (buf_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign frame_ok      = res_out.frame_ok;
    assign rect_payload  = res_out.rect_payload;
    assign point_payload = res_out.point_payload;

endmodule

FILE: rtl/uhtfp_cfg_regs.sv
// ----------------------------------------------------------------------------
// uhtfp_cfg_regs
// Configuration register file: frame mode and marker byte values.
// ----------------------------------------------------------------------------
module uhtfp_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [uhtfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [7:0]                           cfg_data,
    output uhtfp_pkg::uhtfp_cfg_t                cfg
);
    import uhtfp_pkg::*;

    uhtfp_cfg_t cfg_reg;

    // Writes are always accepted
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_mode         <= MODE_RECT;
            cfg_reg.header_first_byte  <= HEADER_FIRST_RST;
            cfg_reg.header_second_byte <= HEADER_SECOND_RST;
            cfg_reg.tail_byte          <= TAIL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (uhtfp_cfg_idx_t'(cfg_index))
                CFG_FRAME_MODE:    cfg_reg.frame_mode         <= cfg_data[1:0];
                CFG_HEADER_FIRST:  cfg_reg.header_first_byte  <= cfg_data;
                CFG_HEADER_SECOND: cfg_reg.header_second_byte <= cfg_data;
                CFG_TAIL:          cfg_reg.tail_byte          <= cfg_data;
            endcase
        end
    end

endmodule

FILE: rtl/uhtfp_out_buf.sv
// ----------------------------------------------------------------------------
// uhtfp_out_buf
// Two-entry result buffer: output register plus skid register, so a new
// byte can be taken while a finished result waits downstream.
// ----------------------------------------------------------------------------
module uhtfp_out_buf (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  uhtfp_pkg::uhtfp_result_t   push_data,
    output logic                       space,
    output logic                       out_valid,
    input  logic                       out_ready,
    output uhtfp_pkg::uhtfp_result_t   out_data
);
    import uhtfp_pkg::*;

    logic          out_valid_reg;
    logic          skid_valid_reg;
    uhtfp_result_t out_data_reg;
    uhtfp_result_t skid_data_reg;
    logic          out_free;

    // Upstream may transfer whenever the skid slot is empty
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

FILE: test/tb_uart_header_tail_frame_parser.sv
// ----------------------------------------------------------------------------
// tb_uart_header_tail_frame_parser
// Self-checking bench for the header/tail framed packet parser. A byte-level
// parser model runs beside the block and predicts every result. Each result
// transfer is checked field by field against the oldest prediction. Both
// channels idle at random, and the receiver holds off once for a long stretch.
// Stimulus covers directed frames, mode changes within a frame and random
// traffic under several register settings.
// ----------------------------------------------------------------------------
module tb_uart_header_tail_frame_parser;

    import uhtfp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    // Mode codes that make the parser ignore bytes
    localparam logic [1:0] MODE_IGNORE     = 2'd2;
    localparam logic [1:0] MODE_IGNORE_ALT = 2'd3;

    // Parser phases of the prediction model
    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_PAYLOAD = 2'd2
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic                   frame_ok;
    logic [63:0]            rect_payload;
    logic [15:0]            point_payload;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // Register shadow and parser state of the model
    logic [1:0]   cfg_mode;
    logic [7:0]   cfg_hdr_first;
    logic [7:0]   cfg_hdr_second;
    logic [7:0]   cfg_tail;
    parse_phase_t phase_now;
    logic [3:0]   stored_count;
    logic [7:0]   rect_bytes [0:RECT_LEN-1];
    logic [7:0]   point_bytes [0:POINT_LEN-1];

    uhtfp_result_t pending_results[$];
    int            mismatches = 0;
    int            bytes_sent = 0;
    int            cycle_count = 0;
    int            hold_req = 0;
    bit            idle_on = 1'b1;

    uart_header_tail_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_ok      (frame_ok),
        .rect_payload  (rect_payload),
        .point_payload (point_payload),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // Advance the parser model by one byte and return the predicted result
    function automatic uhtfp_result_t parse_rx_byte(input logic [7:0] b);
        logic [3:0]    len;
        logic          ok;
        uhtfp_result_t r;
        ok = 1'b0;
        if (cfg_mode == MODE_RECT || cfg_mode == MODE_POINT)
        begin
            len = (cfg_mode == MODE_RECT) ? 4'(RECT_LEN) : 4'(POINT_LEN);
            if (b == cfg_hdr_first && phase_now == PH_HUNT)
            begin
                phase_now = PH_SECOND;
            end
            else if (b == cfg_hdr_second && phase_now == PH_SECOND)
            begin
                phase_now = PH_PAYLOAD;
                stored_count = 4'd0;
            end
            else if (phase_now == PH_PAYLOAD)
            begin
                if (b != cfg_tail)
                begin
                    if (stored_count < len)
                    begin
                        if (cfg_mode == MODE_RECT)
                            rect_bytes[stored_count[RECT_IDX_W-1:0]] = b;
                        else
                            point_bytes[stored_count[POINT_IDX_W-1:0]] = b;
                        stored_count = stored_count + 4'd1;
                    end
                    else
                    begin
                        // overlong payload: abort, byte dropped
                        phase_now = PH_HUNT;
                    end
                end
                else
                begin
                    phase_now = PH_HUNT;
                    ok = (stored_count == len);
                end
            end
            else
            begin
                phase_now = PH_HUNT;
            end
        end
        r.frame_ok = ok;
        for (int k = 0; k < RECT_OUT_BYTES; k++)
            r.rect_payload[8*k +: 8] = rect_bytes[k];
        r.point_payload = {point_bytes[1], point_bytes[0]};
        return r;
    endfunction

    // One byte transfer on the input channel, with a random lead-in gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(parse_rx_byte(b));
        bytes_sent++;
    endtask

    // Stop offering bytes and wait for every predicted result to arrive
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One register write transfer; cfg_valid is left high for back-to-back writes
    task automatic write_reg(input uhtfp_cfg_idx_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_MODE:    cfg_mode       = data[1:0];
            CFG_HEADER_FIRST:  cfg_hdr_first  = data;
            CFG_HEADER_SECOND: cfg_hdr_second = data;
            CFG_TAIL:          cfg_tail       = data;
            default: ;
        endcase
    endtask

    // Drain, then write all four registers; unused mode bits get random values
    task automatic apply_settings(input logic [1:0] mode, input logic [7:0] h1,
                                  input logic [7:0] h2, input logic [7:0] tl);
        logic [5:0] junk;
        junk = 6'($urandom_range(0, 63));
        wait_idle();
        write_reg(CFG_FRAME_MODE, {junk, mode});
        write_reg(CFG_HEADER_FIRST, h1);
        write_reg(CFG_HEADER_SECOND, h2);
        write_reg(CFG_TAIL, tl);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random payload, plus noise and broken ones
    task automatic send_frame();
        int         kind;
        int         len;
        int         n;
        logic [7:0] b;
        kind    = $urandom_range(0, 15);
        idle_on = ($urandom_range(0, 7) != 0);
        len     = (cfg_mode == MODE_POINT) ? POINT_LEN : RECT_LEN;
        if (kind == 14)
        begin
            // line noise
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                b = 8'($urandom_range(0, 255));
                send_byte(b);
            end
        end
        else if (kind == 15)
        begin
            // header broken after the first byte
            send_byte(cfg_hdr_first);
            b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
        else
        begin
            // short or overlong payload now and then
            if (kind >= 11)
                len = $urandom_range(0, len + 3);
            send_byte(cfg_hdr_first);
            send_byte(cfg_hdr_second);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == cfg_tail && kind < 13)
                    b = b ^ 8'h01;
                send_byte(b);
            end
            if (kind != 13 || $urandom_range(0, 1) == 1)
                send_byte(cfg_tail);
        end
    endtask

    // One random phase under a given register setting
    task automatic run_phase(input logic [1:0] mode, input logic [7:0] h1,
                             input logic [7:0] h2, input logic [7:0] tl, input int n);
        int target;
        apply_settings(mode, h1, h2, tl);
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_frame();
        idle_on = 1'b1;
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        // good rectangle frame at reset register values, payload extremes
        seq = '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, 8'hFF, 8'h01, 8'h80,
                8'h5A, 8'hA5, 8'h7F, 8'hFE, TAIL_RST};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
        write_reg(CFG_FRAME_MODE, {6'd0, MODE_POINT});
        cfg_valid <= 1'b0;
        // good point frame, short tail, overlong payload
        seq = '{8'd44, 8'd18, 8'h11, 8'h22, 8'd91, 8'd44, 8'd18, 8'hC3, 8'd91,
                8'd44, 8'd18, 8'h01, 8'h02, 8'h03};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
        // ignore mode: a header changes nothing
        write_reg(CFG_FRAME_MODE, {6'd0, MODE_IGNORE});
        cfg_valid <= 1'b0;
        send_byte(8'd44);
        send_byte(8'd18);
    endtask

    // Phase and count carry over when the mode changes within a frame
    task automatic test_mode_switch();
        logic [7:0] b;
        apply_settings(MODE_RECT, 8'd44, 8'd18, 8'd91);
        send_byte(8'd44);
        send_byte(8'd18);
        send_byte(8'h3C);
        wait_idle();
        write_reg(CFG_FRAME_MODE, {6'd0, MODE_POINT});
        cfg_valid <= 1'b0;
        send_byte(8'hC3);
        send_byte(8'd91);
        send_byte(8'd44);
        send_byte(8'd18);
        send_byte(8'h66);
        send_byte(8'h99);
        wait_idle();
        write_reg(CFG_FRAME_MODE, {6'd0, MODE_RECT});
        cfg_valid <= 1'b0;
        repeat (6)
        begin
            b = 8'($urandom_range(0, 90));
            send_byte(b);
        end
        send_byte(8'd91);
    endtask

    // Long receiver hold-off while bytes keep coming, so the input stalls
    task automatic test_backpressure();
        apply_settings(MODE_RECT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        idle_on  = 1'b0;
        hold_req = 60;
        repeat (5)
        begin
            send_byte(cfg_hdr_first);
            send_byte(cfg_hdr_second);
            repeat (RECT_LEN) send_byte(cfg_tail ^ 8'h40);
            send_byte(cfg_tail);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_phase(MODE_RECT, HEADER_FIRST_RST, HEADER_SECOND_RST, TAIL_RST, 240);
        run_phase(MODE_POINT, 8'h00, 8'hFF, 8'h80, 240);
        run_phase(MODE_RECT, 8'hFF, 8'h00, 8'hFF, 240);
        // equal header bytes
        run_phase(MODE_POINT, 8'h07, 8'h07, 8'hC8, 240);
        run_phase(MODE_IGNORE_ALT, 8'h10, 8'h20, 8'h30, 30);
        run_phase(MODE_RECT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 240);
        run_phase(MODE_POINT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 240);
        run_phase(MODE_IGNORE, 8'hAA, 8'h55, 8'h00, 30);
        // header and tail all the same value
        run_phase(MODE_RECT, 8'h00, 8'h00, 8'h00, 240);
        run_phase(MODE_POINT, 8'hFF, 8'hFF, 8'hFF, 100);
    endtask

    // Receiver: random stall before each result, long hold-off on request
    initial
    begin : result_sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_req) @(posedge clk);
                hold_req = 0;
            end
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    task automatic report_mismatch(input string what, input uhtfp_result_t want,
                                   input uhtfp_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected ok=%0b rect=%h point=%h, got ok=%0b rect=%h point=%h",
                     what, want.frame_ok, want.rect_payload, want.point_payload,
                     got.frame_ok, got.rect_payload, got.point_payload);
    endtask

    // Result check on every output transfer
    always @(posedge clk)
    begin : result_check
        uhtfp_result_t want;
        uhtfp_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.frame_ok      = frame_ok;
            got.rect_payload  = rect_payload;
            got.point_payload = point_payload;
            if (pending_results.size() == 0)
            begin
                want = '0;
                report_mismatch("no result expected", want, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.frame_ok !== want.frame_ok
                    || got.rect_payload !== want.rect_payload
                    || got.point_payload !== want.point_payload)
                    report_mismatch("field", want, got);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        in_valid  <= 1'b0;
        rx_byte   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FRAME_MODE;
        cfg_data  <= 8'h00;
        rst_n     <= 1'b0;
        // model state after reset
        cfg_mode       = MODE_RECT;
        cfg_hdr_first  = HEADER_FIRST_RST;
        cfg_hdr_second = HEADER_SECOND_RST;
        cfg_tail       = TAIL_RST;
        phase_now      = PH_HUNT;
        stored_count   = 4'd0;
        foreach (rect_bytes[i])
            rect_bytes[i] = 8'h00;
        foreach (point_bytes[i])
            point_bytes[i] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_mode_switch();
        test_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
